/* sv/interval_room_allocator_macros.svh */
// Assertion macros for the interval room allocator.
// Used by the top level only; no other dependencies.
`ifndef INTERVAL_ROOM_ALLOCATOR_MACROS_SVH
`define INTERVAL_ROOM_ALLOCATOR_MACROS_SVH
// Implication property under reset.
`define IRA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset.
`define IRA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/ira_pkg.sv */
// Shared types for the interval room allocator.
// No dependencies.
package ira_pkg;
    // Request handed from front to back.
    typedef struct packed {
        logic [31:0] arrival_time;
        logic [31:0] departure_time;
        logic [15:0] booking_tag;
    } req_t;
endpackage

/* sv/ira_front.sv */
// Front part: two-entry request queue between input port and heap engine.
// Depends on ira_pkg.
module ira_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ira_pkg::req_t  in_req,
    output logic           q_valid,
    input  logic           q_take,
    output ira_pkg::req_t  q_req
);
    ira_pkg::req_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_req    = mem_reg[rd_ptr_reg];

    // Store incoming request.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* sv/ira_back.sv */
// Back part: min-heap of (departure, room) in memory, sifted one level at a time.
// Depends on ira_pkg.
module ira_back #(
    parameter int MAX_ROOMS = 256
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_take,
    input  ira_pkg::req_t  q_req,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [8:0]     room_number,
    output logic [15:0]    tag_out,
    output logic [8:0]     rooms_in_use,
    output logic           overflow
);
    localparam int AW = $clog2(MAX_ROOMS);
    localparam int CW = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_TOP, S_CHK, S_DN_RD, S_DN_W1, S_DN_W2, S_DN_CMP,
        S_UP_RD, S_UP_CMP, S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]   dep;
        logic [CW-1:0] room;
    } ent_t;

    ent_t heap_mem [MAX_ROOMS];
    ent_t rd_data_reg;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] other_reg;
    ent_t          cur_reg;
    ent_t          left_reg;
    logic          left_ok_reg;
    ira_pkg::req_t req_reg;
    logic [8:0]    room_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic [8:0]    out_room_reg;
    logic [15:0]   out_tag_reg;
    logic [8:0]    out_use_reg;
    logic          out_ovf_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    ent_t          wr_data;

    logic [CW:0]   lchild;
    logic [CW:0]   rchild;
    logic [CW-1:0] parent;
    ent_t          best_ent;
    logic [CW-1:0] best_pos;

    function automatic logic ent_less(input ent_t a, input ent_t b);
        if (a.dep != b.dep)
        begin
            return a.dep < b.dep;
        end
        return a.room < b.room;
    endfunction

    assign lchild = {pos_reg, 1'b1};
    assign rchild = {pos_reg, 1'b0} + {{CW{1'b0}}, 1'b0} + (CW+1)'(2);
    assign parent = (pos_reg - CW'(1)) >> 1;

    // Heap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    // Pick smaller of current, left and right (right in rd_data_reg).
    always_comb
    begin
        best_ent = cur_reg;
        best_pos = pos_reg;
        if (left_ok_reg && ent_less(left_reg, best_ent))
        begin
            best_ent = left_reg;
            best_pos = lchild[CW-1:0];
        end
        if ((rchild < {1'b0, count_reg}) && ent_less(rd_data_reg, best_ent))
        begin
            best_ent = rd_data_reg;
            best_pos = rchild[CW-1:0];
        end
    end

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg[AW-1:0];
        wr_data = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en = 1'b1;
            end
            S_DN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = lchild[AW-1:0];
            end
            S_DN_W1:
            begin
                rd_en   = 1'b1;
                rd_addr = rchild[AW-1:0];
            end
            S_DN_CMP:
            begin
                wr_en   = 1'b1;
                wr_data = best_ent;
                if (best_pos != pos_reg)
                begin
                    wr_addr = pos_reg[AW-1:0];
                end
            end
            S_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = parent[AW-1:0];
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (pos_reg != '0 && ent_less(cur_reg, rd_data_reg))
                begin
                    wr_data = rd_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign q_take       = (state_reg == S_IDLE) && q_valid;
    assign out_valid    = out_valid_reg;
    assign room_number  = out_room_reg;
    assign tag_out      = out_tag_reg;
    assign rooms_in_use = out_use_reg;
    assign overflow     = out_ovf_reg;

    // Sequencer: top check, then sift down or sift up one level per pass, or straight to output on overflow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            other_reg     <= '0;
            left_ok_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            room_reg      <= '0;
            cur_reg       <= '0;
            left_reg      <= '0;
            req_reg       <= '0;
            out_room_reg  <= '0;
            out_tag_reg   <= '0;
            out_use_reg   <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        req_reg   <= q_req;
                        state_reg <= S_RD_TOP;
                    end
                end
                S_RD_TOP:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    ovf_reg <= 1'b0;
                    if (count_reg != '0 && req_reg.arrival_time > rd_data_reg.dep)
                    begin
                        room_reg     <= 9'(rd_data_reg.room);
                        cur_reg.dep  <= req_reg.departure_time;
                        cur_reg.room <= rd_data_reg.room;
                        pos_reg      <= '0;
                        state_reg    <= S_DN_RD;
                    end
                    else if (count_reg < CW'(MAX_ROOMS))
                    begin
                        room_reg     <= 9'(count_reg + CW'(1));
                        cur_reg.dep  <= req_reg.departure_time;
                        cur_reg.room <= count_reg + CW'(1);
                        pos_reg      <= count_reg;
                        count_reg    <= count_reg + CW'(1);
                        state_reg    <= S_UP_RD;
                    end
                    else
                    begin
                        room_reg  <= '0;
                        ovf_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_DN_RD:
                begin
                    left_ok_reg <= lchild < {1'b0, count_reg};
                    state_reg   <= S_DN_W1;
                end
                S_DN_W1:
                begin
                    // Left child data arrives now; right child read is issued.
                    left_reg  <= rd_data_reg;
                    state_reg <= S_DN_W2;
                end
                S_DN_W2:
                begin
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    // Winner moved up into pos; carry current down to its slot.
                    if (best_pos != pos_reg)
                    begin
                        pos_reg   <= best_pos;
                        state_reg <= S_DN_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_UP_RD:
                begin
                    other_reg <= parent;
                    state_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (pos_reg != '0 && ent_less(cur_reg, rd_data_reg))
                    begin
                        pos_reg   <= other_reg;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // Load the result register once the previous one has left.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_room_reg  <= room_reg;
                        out_tag_reg   <= req_reg.booking_tag;
                        out_use_reg   <= 9'(count_reg);
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

/* sv/interval_room_allocator.sv */
// Interval room allocator.
// Channels: input bookings (arrival_time, departure_time, booking_tag) with
// in_valid/in_stall, results (room_number, tag_out, rooms_in_use, overflow)
// with out_valid/out_stall. An item is taken when valid is high and stall low.
// A two-entry queue feeds a heap engine that keeps (departure, room) pairs in
// one single-port-read memory. A taken booking is registered in the queue
// before the engine can take it; the engine reads the heap top, then sifts
// down (read left child, read right child, wait, compare and write; the final
// level that swaps nothing included) or sifts up (read parent, compare and
// write) one level at a time, then loads the result register. On overflow it
// goes straight from the top check to the result. The engine can take the
// next booking in the cycle after it loads a result.
// Reset empties the heap and queue; no clearing pass is needed since only
// entries below the room count are used.
// When the receiver stalls, the result register holds; the engine finishes
// the next booking and waits, and the queue keeps taking bookings until it
// holds two.
module interval_room_allocator #(
    parameter int MAX_ROOMS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] arrival_time,
    input  logic [31:0] departure_time,
    input  logic [15:0] booking_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  room_number,
    output logic [15:0] tag_out,
    output logic [8:0]  rooms_in_use,
    output logic        overflow
);
    ira_pkg::req_t in_req;
    ira_pkg::req_t q_req;
    logic          q_valid;
    logic          q_take;

    assign in_req.arrival_time   = arrival_time;
    assign in_req.departure_time = departure_time;
    assign in_req.booking_tag    = booking_tag;

    ira_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_req    (q_req)
    );

    ira_back #(.MAX_ROOMS(MAX_ROOMS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_req        (q_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .room_number  (room_number),
        .tag_out      (tag_out),
        .rooms_in_use (rooms_in_use),
        .overflow     (overflow)
    );

`include "interval_room_allocator_macros.svh"

    `IRA_ASSERT_IMP(a_ovf_room_zero, out_valid && overflow, room_number == 9'd0)
    `IRA_ASSERT_IMP(a_room_range, out_valid && !overflow,
        room_number != 9'd0 && room_number <= rooms_in_use)
    `IRA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(room_number))
endmodule

/* dv/tb_top.sv */
// Testbench for the interval room allocator: drives bookings, predicts room
// assignment with a local min-heap model and checks every result.
// Depends on sv/interval_room_allocator.sv (and ira_pkg).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOM_LIMIT = 256;

    typedef struct {
        logic [8:0]  room;
        logic [15:0] tag;
        logic [8:0]  in_use;
        logic        ovf;
    } alloc_t;

    // Room allocation predictor and pending result store
    class room_scoreboard;
        bit [31:0] dep_key [ROOM_LIMIT];
        bit [8:0]  room_id [ROOM_LIMIT];
        int        open_rooms;
        alloc_t    pending[$];
        int        errors;

        function bit earlier(int i, int j);
            if (dep_key[i] != dep_key[j])
                return dep_key[i] < dep_key[j];
            return room_id[i] < room_id[j];
        endfunction

        function void swap_entries(int i, int j);
            bit [31:0] d;
            bit [8:0]  r;
            d = dep_key[i]; dep_key[i] = dep_key[j]; dep_key[j] = d;
            r = room_id[i]; room_id[i] = room_id[j]; room_id[j] = r;
        endfunction

        // Predict the result of an accepted request and update the heap
        function void note_booking(bit [31:0] arr, bit [31:0] dep, bit [15:0] tag);
            alloc_t a;
            int     pos;
            int     best;
            int     l;
            a.room = 0;
            a.ovf  = 0;
            a.tag  = tag;
            if (open_rooms > 0 && arr > dep_key[0])
            begin
                a.room = room_id[0];
                dep_key[0] = dep;
                pos = 0;
                forever
                begin
                    l = 2 * pos + 1;
                    best = pos;
                    if (l < open_rooms && earlier(l, best)) best = l;
                    if (l + 1 < open_rooms && earlier(l + 1, best)) best = l + 1;
                    if (best == pos) break;
                    swap_entries(pos, best);
                    pos = best;
                end
            end
            else if (open_rooms < ROOM_LIMIT)
            begin
                a.room = 9'(open_rooms + 1);
                dep_key[open_rooms] = dep;
                room_id[open_rooms] = 9'(open_rooms + 1);
                pos = open_rooms;
                open_rooms++;
                while (pos > 0 && earlier(pos, (pos - 1) / 2))
                begin
                    swap_entries(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
            end
            else
                a.ovf = 1;
            a.in_use = open_rooms[8:0];
            pending = {pending, a};
        endfunction

        // Compare a result against the oldest prediction
        function void check_result(alloc_t got);
            alloc_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result room=%0d tag=%h", $time, got.room, got.tag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.room !== e.room || got.tag !== e.tag || got.in_use !== e.in_use ||
                got.ovf !== e.ovf)
            begin
                $display("%0t: mismatch exp room=%0d tag=%h use=%0d ovf=%b",
                         $time, e.room, e.tag, e.in_use, e.ovf);
                $display("%0t:          got room=%0d tag=%h use=%0d ovf=%b",
                         $time, got.room, got.tag, got.in_use, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] arrival_time = 0;
    logic [31:0] departure_time = 0;
    logic [15:0] booking_tag = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [8:0]  room_number;
    logic [15:0] tag_out;
    logic [8:0]  rooms_in_use;
    logic        overflow;

    room_scoreboard board = new();
    bit             recv_run = 1;
    bit [31:0]      clock_now;

    interval_room_allocator #(.MAX_ROOMS(ROOM_LIMIT)) dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Offer one request and hold it until taken; valid stays up for the next
    task automatic send_booking(bit [31:0] arr, bit [31:0] dep, bit [15:0] tag);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_valid       <= 1;
        arrival_time   <= arr;
        departure_time <= dep;
        booking_tag    <= tag;
        do @(posedge clk); while (in_stall);
        board.note_booking(arr, dep, tag);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    // Sample results at the rising edge
    always @(posedge clk)
    begin
        alloc_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.room = room_number;
            got.tag = tag_out;
            got.in_use = rooms_in_use;
            got.ovf = overflow;
            board.check_result(got);
        end
    end

    // Randomly stall the result side, with calm stretches
    initial
    begin
        int g;
        while (recv_run)
        begin
            @(negedge clk);
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g != 0)
            begin
                out_stall <= 1;
                repeat (g) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int k;
        bit [31:0] a;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: empty heap, equal times, reuse, field extremes
        send_booking(32'd10, 32'd20, 16'h0000);
        send_booking(32'd20, 32'd30, 16'hFFFF);
        send_booking(32'd21, 32'd25, 16'h5A5A);
        send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hA5A5);
        send_booking(32'd0, 32'd0, 16'h1234);
        send_booking(32'd5, 32'd3, 16'h0001);
        drain();

        // Fill every room with departures that never free, then overflow
        for (k = 0; k < ROOM_LIMIT + 4; k++)
            send_booking(32'd0, 32'hFFFF_FFFF - k[31:0], k[15:0]);
        drain();

        // Random: presorted arrivals with mostly short stays, some long stays and unsorted noise
        clock_now = 0;
        for (k = 0; k < 750; k++)
        begin
            clock_now += $urandom_range(0, 6);
            a = clock_now;
            if ($urandom_range(0, 19) == 0) a = $urandom();
            send_booking(a, a + $urandom_range(0, 40) +
                         (($urandom_range(0, 9) == 0) ? $urandom() : 0),
                         16'($urandom()));
            if (k == 375) drain();
        end
        drain();
        repeat (100) @(negedge clk);
        recv_run = 0;
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/ira_pkg.sv
sv/ira_front.sv
sv/ira_back.sv
sv/interval_room_allocator.sv
dv/tb_top.sv
